/* hdl/njd_pkg.sv */
// Shared types and constants for the job dispatcher.
// No dependencies.
package njd_pkg;
    localparam int TableSlotsDefault = 16;

    localparam logic [1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_DISPATCH  = 2'd2;
    localparam logic [1:0] ST_NONE      = 2'd3;

    localparam logic REQ_SUBMIT   = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    localparam logic [0:0] REG_POLICY = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_E,   // earliest arrival / free slot search
        S_SCAN_P,   // pick best arrived job
        S_FETCH,
        S_CALC,
        S_DIV,
        S_DONE
    } t_state;
endpackage

/* hdl/njd_div.sv */
// Restoring divider: (turn << 8) / burst, one quotient bit per cycle.
// Depends on njd_pkg (style only).
module njd_div
    import njd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_turn,
    input  logic [7:0]  i_burst,
    output logic        o_done,
    output logic [23:0] o_quot
);
    logic [23:0] r_num, n_num;
    logic [8:0]  r_rem, n_rem;
    logic [7:0]  r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [9:0]  w_try;

    always_comb begin
        w_try = {r_rem, r_num[23]};
        n_num = {r_num[22:0], 1'b0};
        if (w_try >= {2'b0, r_den}) begin
            n_rem   = 9'(w_try - {2'b0, r_den});
            n_num[0] = 1'b1;
        end else begin
            n_rem = w_try[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_num  <= {i_turn, 8'd0};
                r_rem  <= '0;
                r_den  <= i_burst;
            end else if (r_busy) begin
                r_num <= n_num;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd23) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_num;
endmodule

/* hdl/nonpreemptive_job_dispatcher_top.sv */
// Job dispatcher with shortest-job and response-ratio policies: one item at a
// time; busy stays high until the single result strobe, and a new item can be
// taken in the strobe cycle. A submit runs a free-slot scan over the valid
// bits. A dispatch runs a scan through the table memory for the earliest
// arrival and, if the table holds any job, a scan with a registered
// cross-multiply per slot that repeats a slot read after each eligible job,
// then the serial divider. The receiver cannot stall the result strobe.
// Depends on njd_pkg and njd_div.
module nonpreemptive_job_dispatcher_top
    import njd_pkg::*;
#(
    parameter int TABLE_SLOTS = TableSlotsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [7:0]  i_job_id,
    input  logic [15:0] i_arrival_time,
    input  logic [7:0]  i_burst_time,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [7:0]  o_chosen_id,
    output logic [15:0] o_wait_ticks,
    output logic [15:0] o_finish_time,
    output logic [15:0] o_turnaround,
    output logic [23:0] o_tat_ratio,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = AW + 1;

    // table memory: {job, arrival, burst}
    logic [31:0] mem [TABLE_SLOTS];
    logic [31:0] r_rd;
    logic [TABLE_SLOTS-1:0] r_valid;

    logic r_policy;
    assign pready = 1'b1;
    assign prdata = {31'd0, r_policy};

    t_state r_st, n_st;
    logic [CW-1:0] r_idx;          // address issued
    logic [AW-1:0] r_pidx;         // address of data in r_rd
    logic          r_pv;           // r_rd holds a scan entry
    logic          r_req;
    logic [7:0]    r_jid;
    logic [15:0]   r_arr_in;
    logic [7:0]    r_bur_in;
    logic [15:0]   r_now;
    logic          r_any;
    logic [15:0]   r_earl;
    logic          r_found;
    logic [AW-1:0] r_best;
    logic [7:0]    r_bj, r_bb;
    logic [15:0]   r_ba;
    // cross multiply stage
    logic          r_mv;
    logic [AW-1:0] r_midx;
    logic [7:0]    r_mj, r_mb;
    logic [15:0]   r_ma;
    logic [24:0]   r_lc, r_lb;
    logic [15:0]   r_wait, r_fin, r_turn;
    logic          r_dstart;
    logic          w_ddone;
    logic [23:0]   w_quot;

    logic [7:0]  e_j, e_b;
    logic [15:0] e_a;
    assign e_j = r_rd[31:24];
    assign e_a = r_rd[23:8];
    assign e_b = r_rd[7:0];

    logic w_last;
    assign w_last = (r_idx == CW'(TABLE_SLOTS));

    // a candidate still in the multiply stage forces the entry in r_rd to be
    // read again, so the read goes back to that entry
    logic          w_retry;
    logic [AW-1:0] w_raddr;
    assign w_retry = r_pv && r_mv;
    assign w_raddr = w_retry ? r_pidx : r_idx[AW-1:0];

    // response ratio numerators: wait + burst
    logic [16:0] w_nc, w_nb;
    assign w_nc = {1'b0, 16'(r_now - e_a)} + {9'd0, e_b};
    assign w_nb = {1'b0, 16'(r_now - r_ba)} + {9'd0, r_bb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_policy <= 1'b0;
        else if (psel && penable && pwrite && paddr == 2'(REG_POLICY))
            r_policy <= pwdata[0];
    end

    logic w_acc;
    assign w_acc = start && !busy;
    assign busy  = (r_st != S_IDLE);

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: begin
                if (w_acc) n_st = S_SCAN_E;
            end
            S_SCAN_E: begin
                if (w_last && r_req == REQ_SUBMIT) n_st = S_DONE;
                else if (w_last && !r_pv) n_st = r_any ? S_SCAN_P : S_DONE;
            end
            S_SCAN_P: begin
                if (w_last && !r_pv && !r_mv) n_st = S_FETCH;
            end
            S_FETCH:  n_st = S_CALC;
            S_CALC:   n_st = S_DIV;
            S_DIV: begin
                if (w_ddone) n_st = S_DONE;
            end
            S_DONE:   n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= S_IDLE;
        else          r_st <= n_st;
    end

    // candidate beats current best (cross multiply already registered)
    logic w_beat;
    always_comb begin
        if (r_policy) begin
            if (r_lc != r_lb) w_beat = r_lc > r_lb;
            else              w_beat = r_mj < r_bj;
        end else begin
            if (r_mb != r_bb) w_beat = r_mb < r_bb;
            else              w_beat = r_mj < r_bj;
        end
    end

    logic [16:0] w_fin;
    assign w_fin = {1'b0, r_now} + {9'd0, r_bb};

    always_ff @(posedge i_clk) begin
        r_rd <= mem[w_raddr];
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_now    <= '0;
            o_strobe <= 1'b0;
            r_pv     <= 1'b0;
            r_mv     <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            r_dstart <= 1'b0;
            r_pv     <= 1'b0;
            r_mv     <= 1'b0;
            case (r_st)
                S_IDLE: if (w_acc) begin
                    r_req    <= i_req_type;
                    r_jid    <= i_job_id;
                    r_arr_in <= i_arrival_time;
                    r_bur_in <= (i_burst_time == 8'd0) ? 8'd1 : i_burst_time;
                    r_idx    <= '0;
                    r_any    <= 1'b0;
                    r_found  <= 1'b0;
                    r_earl   <= 16'hFFFF;
                end
                S_SCAN_E: begin
                    if (r_req == REQ_SUBMIT) begin
                        // free slot search on valid bits only
                        if (!w_last) begin
                            if (!r_found && !r_valid[r_idx[AW-1:0]]) begin
                                r_found <= 1'b1;
                                r_best  <= r_idx[AW-1:0];
                            end
                            r_idx <= r_idx + CW'(1);
                        end
                    end else begin
                        if (!w_last) begin
                            r_pv   <= 1'b1;
                            r_pidx <= r_idx[AW-1:0];
                            r_idx  <= r_idx + CW'(1);
                        end
                        if (r_pv && r_valid[r_pidx]) begin
                            r_any <= 1'b1;
                            if (e_a < r_earl) r_earl <= e_a;
                        end
                        if (w_last && !r_pv) begin
                            r_idx <= '0;
                            if (r_any && r_earl > r_now) r_now <= r_earl;
                        end
                    end
                end
                S_SCAN_P: begin
                    if (w_retry) begin
                        // products for this entry used the old best: redo it
                        r_pv <= 1'b1;
                    end else begin
                        if (!w_last) begin
                            r_pv   <= 1'b1;
                            r_pidx <= r_idx[AW-1:0];
                            r_idx  <= r_idx + CW'(1);
                        end
                        if (r_pv && r_valid[r_pidx] && e_a <= r_now) begin
                            r_mv   <= 1'b1;
                            r_midx <= r_pidx;
                            r_mj <= e_j; r_ma <= e_a; r_mb <= e_b;
                            r_lc <= 25'(w_nc) * 25'(r_bb);
                            r_lb <= 25'(w_nb) * 25'(e_b);
                        end
                    end
                    if (r_mv && (!r_found || w_beat)) begin
                        r_found <= 1'b1;
                        r_best <= r_midx;
                        r_bj <= r_mj; r_ba <= r_ma; r_bb <= r_mb;
                    end
                end
                S_FETCH: begin
                    r_wait <= r_now - r_ba;
                    r_fin  <= w_fin[16] ? 16'hFFFF : w_fin[15:0];
                end
                S_CALC: begin
                    r_now  <= r_fin;
                    r_turn <= r_fin - r_ba;
                    r_valid[r_best] <= 1'b0;
                    r_dstart <= 1'b1;
                end
                S_DONE: begin
                    o_strobe <= 1'b1;
                    o_chosen_id <= '0; o_wait_ticks <= '0; o_finish_time <= '0;
                    o_turnaround <= '0; o_tat_ratio <= '0;
                    if (r_req == REQ_SUBMIT) begin
                        o_status <= r_found ? ST_ACCEPTED : ST_FULL;
                        if (r_found) r_valid[r_best] <= 1'b1;
                    end else if (!r_any) begin
                        o_status <= ST_NONE;
                    end else begin
                        o_status <= ST_DISPATCH;
                        o_chosen_id <= r_bj;
                        o_wait_ticks <= r_wait;
                        o_finish_time <= r_now;
                        o_turnaround <= r_turn;
                        o_tat_ratio <= w_quot;
                    end
                end
                default: ;
            endcase
        end
    end

    // table write on an accepted submit
    always_ff @(posedge i_clk) begin
        if (r_st == S_DONE && r_req == REQ_SUBMIT && r_found)
            mem[r_best] <= {r_jid, r_arr_in, r_bur_in};
    end

    njd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_turn  (r_turn),
        .i_burst (r_bb),
        .o_done  (w_ddone),
        .o_quot  (w_quot)
    );
endmodule

/* hdl/njd_checker.sv */
// Port-level checks for the dispatcher; bound to the top level.
// Depends on njd_pkg.
module njd_checker
    import njd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [1:0]  o_status,
    input logic [15:0] o_finish_time,
    input logic [15:0] o_turnaround,
    input logic [15:0] o_wait_ticks
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted beat not taken");
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy)) else $error("strobe without work");
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy) else $error("busy after result");
    // equal only when the time counter is already pinned at its maximum
    a_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_DISPATCH) |-> o_turnaround >= o_wait_ticks)
        else $error("turnaround below wait");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_DISPATCH) |-> o_finish_time == 16'd0)
        else $error("timing on non-dispatch");
endmodule

bind nonpreemptive_job_dispatcher_top njd_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_strobe(o_strobe), .o_status(o_status), .o_finish_time(o_finish_time),
    .o_turnaround(o_turnaround), .o_wait_ticks(o_wait_ticks)
);
